>>> hdl/sre_pkg.sv
// Shared types and constants for the slice reassembly engine.
// No dependencies; used by sre_frame_store and slice_reassembly_engine.
package sre_pkg;

    localparam logic [31:0] FRAME_SENTINEL     = 32'hFFFF_FFFF;
    localparam logic [7:0]  HEADER_BYTES_RESET = 8'd28;
    localparam int unsigned CFG_ADDR_W         = 1;
    localparam int unsigned IN_TDATA_W         = 256;
    localparam int unsigned OUT_TDATA_W        = 72;

    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC_WORD   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTES = 1'd1;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_READ   = 2'd2
    } sre_kind_t;

    typedef enum logic [3:0] {
        ST_ACCEPTED    = 4'd0,
        ST_SHORT       = 4'd1,
        ST_BAD_MAGIC   = 4'd2,
        ST_STALE       = 4'd3,
        ST_BAD_SLICE   = 4'd4,
        ST_OUT_BOUNDS  = 4'd5,
        ST_TOO_LARGE   = 4'd6,
        ST_BYTE_WRITE  = 4'd7,
        ST_BYTE_IGNORE = 4'd8,
        ST_READ_DONE   = 4'd9,
        ST_EMPTY_DONE  = 4'd10
    } sre_status_t;

    // Frame store port controls
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } sre_store_ctl_t;

endpackage

>>> hdl/sre_frame_store.sv
// Frame store: single-port-write, single-port-read byte memory with a registered read.
// Depends on sre_pkg for the port control struct.
module sre_frame_store #(
    parameter int unsigned DEPTH = 65536,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  sre_pkg::sre_store_ctl_t ctl,
    input  logic [AW-1:0]           wr_addr,
    input  logic [7:0]              wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/slice_reassembly_engine.sv
// Slice reassembly engine: frame header checks, slice bitmap and byte frame store.
// Each accepted item's result is registered in the s1 stage, then in the output stage,
// before it is offered. Throughput: one item per cycle; the input stalls only while both
// result stages are full and m_tready is low. Each payload byte takes the store write port,
// a read the read port. Reset (rst_n, async, active low) clears control state and the
// slice bitmap at once; frame store contents are undefined until written.
// Depends on sre_pkg and sre_frame_store.
module slice_reassembly_engine #(
    parameter int unsigned STORE_BYTES = 65536,
    parameter int unsigned MAX_SLICES  = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // cfg: register index 0 magic_word, 1 header_bytes
    input  logic                               cfg_we,
    input  logic [sre_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [31:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // magic[31:0], frame_id[63:32], frame_size[95:64], pixels_in_frame[127:96],
    // slice_number[143:128], slices_in_frame[159:144], payload_offset[191:160],
    // payload_length[207:192], datagram_length[224:208], data_byte[232:225],
    // read_address[248:233], zero fill above
    input  logic [sre_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind[1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // done_frame_id[31:0], done_pixel_count[63:32], read_data[71:64]
    output logic [sre_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[3:0]
    output logic [3:0]                         m_tuser,
    // frame_complete
    output logic                               m_tlast
);

    localparam int unsigned SAW = $clog2(STORE_BYTES);
    localparam int unsigned SZW = $clog2(STORE_BYTES + 1);
    localparam int unsigned SLW = $clog2(MAX_SLICES + 1);
    localparam int unsigned SIW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

    // input fields
    logic [31:0] in_magic, in_frame_id, in_frame_size, in_pixels, in_offset;
    logic [15:0] in_slice, in_slices, in_plen, in_read_addr;
    logic [16:0] in_dlen;
    logic [7:0]  in_byte;

    assign in_magic      = s_tdata[31:0];
    assign in_frame_id   = s_tdata[63:32];
    assign in_frame_size = s_tdata[95:64];
    assign in_pixels     = s_tdata[127:96];
    assign in_slice      = s_tdata[143:128];
    assign in_slices     = s_tdata[159:144];
    assign in_offset     = s_tdata[191:160];
    assign in_plen       = s_tdata[207:192];
    assign in_dlen       = s_tdata[224:208];
    assign in_byte       = s_tdata[232:225];
    assign in_read_addr  = s_tdata[248:233];

    // configuration and assembly state
    logic [31:0]           magic_word_reg;
    logic [7:0]            header_bytes_reg;
    logic [31:0]           cur_frame_reg,   cur_frame_next;
    logic [SZW-1:0]        cur_size_reg,    cur_size_next;
    logic [31:0]           cur_pixels_reg,  cur_pixels_next;
    logic [SLW-1:0]        slice_total_reg, slice_total_next;
    logic [MAX_SLICES-1:0] seen_reg,        seen_next;
    logic [SLW-1:0]        seen_count_reg,  seen_count_next;
    logic [SAW-1:0]        wptr_reg,        wptr_next;
    logic [15:0]           bytes_left_reg,  bytes_left_next;
    logic [SIW-1:0]        pending_reg,     pending_next;
    logic                  accepting_reg,   accepting_next;

    // pipeline and output stage
    logic                  s1_valid_reg;
    logic [3:0]            s1_status_reg;
    logic                  s1_complete_reg;
    logic [31:0]           s1_frame_reg;
    logic [31:0]           s1_pixels_reg;
    logic                  s1_read_reg;
    logic                  out_valid_reg;
    logic [3:0]            out_status_reg;
    logic                  out_complete_reg;
    logic [31:0]           out_frame_reg;
    logic [31:0]           out_pixels_reg;
    logic [7:0]            out_rdata_reg;

    logic                  accept;
    logic                  s1_move;
    sre_pkg::sre_status_t  status;
    logic                  complete;
    logic                  rd_in_range;
    logic                  byte_write;
    sre_pkg::sre_store_ctl_t store_ctl;
    logic [7:0]            store_rdata;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    assign rd_in_range = {16'd0, in_read_addr} < 32'(STORE_BYTES);

    always_comb
    begin
        logic           restart;
        logic           too_large;
        logic [31:0]    eff_frame;
        logic [SZW-1:0] eff_size;
        logic [SLW-1:0] eff_total;
        logic [SLW-1:0] eff_count;
        logic           slice_in_map;
        logic           slice_seen_bit;
        logic           bad_slice;
        logic           oob;
        logic [SLW-1:0] count_inc;
        logic [SIW-1:0] slice_idx;

        cur_frame_next   = cur_frame_reg;
        cur_size_next    = cur_size_reg;
        cur_pixels_next  = cur_pixels_reg;
        slice_total_next = slice_total_reg;
        seen_next        = seen_reg;
        seen_count_next  = seen_count_reg;
        wptr_next        = wptr_reg;
        bytes_left_next  = bytes_left_reg;
        pending_next     = pending_reg;
        accepting_next   = accepting_reg;
        status           = sre_pkg::ST_BYTE_IGNORE;
        complete         = 1'b0;
        byte_write       = 1'b0;

        restart   = (in_frame_id > cur_frame_reg) || (cur_frame_reg == sre_pkg::FRAME_SENTINEL);
        too_large = (in_frame_size > 32'(STORE_BYTES)) || (32'(in_slices) > 32'(MAX_SLICES));
        eff_frame = restart ? in_frame_id : cur_frame_reg;
        eff_size  = restart ? SZW'(in_frame_size) : cur_size_reg;
        eff_total = restart ? SLW'(in_slices) : slice_total_reg;
        eff_count = restart ? '0 : seen_count_reg;
        slice_idx = SIW'(in_slice);
        slice_in_map   = 32'(in_slice) < 32'(MAX_SLICES);
        slice_seen_bit = slice_in_map && !restart && seen_reg[slice_idx];
        bad_slice = (32'(in_slice) >= 32'(eff_total)) || !slice_in_map || slice_seen_bit;
        oob = ({1'b0, in_offset} + 33'(in_plen) > 33'(eff_size))
              || (18'(header_bytes_reg) + 18'(in_plen) > 18'(in_dlen));
        count_inc = SLW'(eff_count + 1'b1);

        if (accept)
        begin
            case (s_tuser)
                sre_pkg::KIND_HEADER:
                begin
                    // abandon any pending payload
                    accepting_next  = 1'b0;
                    bytes_left_next = '0;
                    if (in_dlen < 17'(header_bytes_reg))
                    begin
                        status = sre_pkg::ST_SHORT;
                    end
                    else if (in_magic != magic_word_reg)
                    begin
                        status = sre_pkg::ST_BAD_MAGIC;
                    end
                    else if (restart && too_large)
                    begin
                        status = sre_pkg::ST_TOO_LARGE;
                    end
                    else
                    begin
                        if (restart)
                        begin
                            cur_frame_next   = in_frame_id;
                            cur_size_next    = eff_size;
                            cur_pixels_next  = in_pixels;
                            slice_total_next = eff_total;
                            seen_next        = '0;
                            seen_count_next  = '0;
                        end
                        if (in_frame_id != eff_frame)
                        begin
                            status = sre_pkg::ST_STALE;
                        end
                        else if (bad_slice)
                        begin
                            status = sre_pkg::ST_BAD_SLICE;
                        end
                        else if (oob)
                        begin
                            status = sre_pkg::ST_OUT_BOUNDS;
                        end
                        else if (in_plen == 16'd0)
                        begin
                            status = sre_pkg::ST_EMPTY_DONE;
                            seen_next[slice_idx] = 1'b1;
                            seen_count_next      = count_inc;
                            complete             = (count_inc == eff_total);
                        end
                        else
                        begin
                            status          = sre_pkg::ST_ACCEPTED;
                            wptr_next       = SAW'(in_offset);
                            bytes_left_next = in_plen;
                            pending_next    = slice_idx;
                            accepting_next  = 1'b1;
                        end
                    end
                end
                sre_pkg::KIND_BYTE:
                begin
                    if (accepting_reg && (bytes_left_reg != 16'd0))
                    begin
                        status          = sre_pkg::ST_BYTE_WRITE;
                        byte_write      = 1'b1;
                        wptr_next       = SAW'(wptr_reg + 1'b1);
                        bytes_left_next = bytes_left_reg - 16'd1;
                        // last byte: mark the slice received
                        if (bytes_left_reg == 16'd1)
                        begin
                            accepting_next = 1'b0;
                            if (!seen_reg[pending_reg])
                            begin
                                seen_next[pending_reg] = 1'b1;
                                seen_count_next = SLW'(seen_count_reg + 1'b1);
                                complete = (SLW'(seen_count_reg + 1'b1) == slice_total_reg);
                            end
                        end
                    end
                end
                sre_pkg::KIND_READ:
                begin
                    status = sre_pkg::ST_READ_DONE;
                end
                default:
                begin
                    status = sre_pkg::ST_BYTE_IGNORE;
                end
            endcase
        end
    end

    assign store_ctl.wr_en = byte_write;
    assign store_ctl.rd_en = accept && (s_tuser == sre_pkg::KIND_READ) && rd_in_range;

    sre_frame_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .ctl     (store_ctl),
        .wr_addr (wptr_reg),
        .wr_data (in_byte),
        .rd_addr (SAW'(in_read_addr)),
        .rd_data (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg   <= '0;
            header_bytes_reg <= sre_pkg::HEADER_BYTES_RESET;
            cur_frame_reg    <= sre_pkg::FRAME_SENTINEL;
            cur_size_reg     <= '0;
            cur_pixels_reg   <= '0;
            slice_total_reg  <= '0;
            seen_reg         <= '0;
            seen_count_reg   <= '0;
            wptr_reg         <= '0;
            bytes_left_reg   <= '0;
            pending_reg      <= '0;
            accepting_reg    <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    sre_pkg::REG_MAGIC_WORD:   magic_word_reg   <= cfg_wdata;
                    sre_pkg::REG_HEADER_BYTES: header_bytes_reg <= cfg_wdata[7:0];
                    default:                   magic_word_reg   <= magic_word_reg;
                endcase
            end
            cur_frame_reg   <= cur_frame_next;
            cur_size_reg    <= cur_size_next;
            cur_pixels_reg  <= cur_pixels_next;
            slice_total_reg <= slice_total_next;
            seen_reg        <= seen_next;
            seen_count_reg  <= seen_count_next;
            wptr_reg        <= wptr_next;
            bytes_left_reg  <= bytes_left_next;
            pending_reg     <= pending_next;
            accepting_reg   <= accepting_next;

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg   <= status;
            s1_complete_reg <= complete;
            s1_frame_reg    <= cur_frame_next;
            s1_pixels_reg   <= cur_pixels_next;
            s1_read_reg     <= store_ctl.rd_en;
        end
        if (s1_move)
        begin
            out_status_reg   <= s1_status_reg;
            out_complete_reg <= s1_complete_reg;
            out_frame_reg    <= s1_frame_reg;
            out_pixels_reg   <= s1_pixels_reg;
            out_rdata_reg    <= s1_read_reg ? store_rdata : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rdata_reg, out_pixels_reg, out_frame_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_complete_reg;

endmodule

>>> test/slice_result_checker.sv
// Checker for the slice reassembly engine: watches the config port and both streams,
// predicts each result from its own copy of the frame state and compares field by field.
// Depends on sre_pkg for the kind and status codes and the port widths.
`timescale 1ns / 1ps

module slice_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sre_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sre_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [sre_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic [3:0]                      m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              outstanding
);

    localparam int unsigned STORE_SIZE  = 65536;
    localparam int unsigned SLICE_LIMIT = 64;

    typedef struct {
        sre_pkg::sre_status_t status;
        bit                   complete;
        bit [31:0]            frame_id;
        bit [31:0]            pixels;
        bit [7:0]             rdata;
    } frame_result_t;

    frame_result_t result_q[$];

    bit [31:0]   magic_reg;
    bit [7:0]    hdr_reg;
    bit [31:0]   frame_no;
    bit [16:0]   frame_len;
    bit [31:0]   frame_pixels;
    bit [6:0]    slice_count;
    bit          slice_got [SLICE_LIMIT];
    bit [6:0]    got_count;
    bit [7:0]    store_mem [STORE_SIZE];
    int unsigned wr_addr;
    int unsigned wr_left;
    bit [5:0]    wr_slice;
    bit          wr_busy;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Mark a slice received; true when it was the last one missing.
    function automatic bit note_slice(input int unsigned idx);
        if (idx >= SLICE_LIMIT || slice_got[idx])
            return 1'b0;
        slice_got[idx] = 1'b1;
        got_count++;
        return got_count == slice_count;
    endfunction

    function automatic sre_pkg::sre_status_t take_header(
        input logic [sre_pkg::IN_TDATA_W-1:0] d, output bit done);
        logic [31:0] mg;
        logic [31:0] fid;
        logic [31:0] fsize;
        logic [31:0] pix;
        logic [15:0] snum;
        logic [15:0] stot;
        logic [31:0] off;
        logic [15:0] plen;
        logic [16:0] dlen;
        mg    = d[31:0];
        fid   = d[63:32];
        fsize = d[95:64];
        pix   = d[127:96];
        snum  = d[143:128];
        stot  = d[159:144];
        off   = d[191:160];
        plen  = d[207:192];
        dlen  = d[224:208];
        done  = 1'b0;
        // drop any payload still pending
        wr_busy = 1'b0;
        wr_left = 0;
        if (dlen < hdr_reg)
            return sre_pkg::ST_SHORT;
        if (mg != magic_reg)
            return sre_pkg::ST_BAD_MAGIC;
        if (fid > frame_no || frame_no == sre_pkg::FRAME_SENTINEL)
        begin
            if (fsize > STORE_SIZE || stot > SLICE_LIMIT)
                return sre_pkg::ST_TOO_LARGE;
            frame_no     = fid;
            frame_len    = fsize[16:0];
            frame_pixels = pix;
            slice_count  = stot[6:0];
            foreach (slice_got[i])
                slice_got[i] = 1'b0;
            got_count = '0;
        end
        if (fid != frame_no)
            return sre_pkg::ST_STALE;
        if (snum >= slice_count || snum >= SLICE_LIMIT || slice_got[snum])
            return sre_pkg::ST_BAD_SLICE;
        if (longint'(off) + longint'(plen) > longint'(frame_len)
            || int'(hdr_reg) + int'(plen) > int'(dlen))
            return sre_pkg::ST_OUT_BOUNDS;
        if (plen == 0)
        begin
            done = note_slice(snum);
            return sre_pkg::ST_EMPTY_DONE;
        end
        wr_addr  = off;
        wr_left  = plen;
        wr_slice = snum[5:0];
        wr_busy  = 1'b1;
        return sre_pkg::ST_ACCEPTED;
    endfunction

    function automatic sre_pkg::sre_status_t take_byte(input logic [7:0] b, output bit done);
        done = 1'b0;
        if (!wr_busy || wr_left == 0)
            return sre_pkg::ST_BYTE_IGNORE;
        if (wr_addr < STORE_SIZE)
            store_mem[wr_addr] = b;
        wr_addr++;
        wr_left--;
        if (wr_left == 0)
        begin
            wr_busy = 1'b0;
            done = note_slice(wr_slice);
        end
        return sre_pkg::ST_BYTE_WRITE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        bit done;
        if (!rst_n)
        begin
            fail_count   = 0;
            magic_reg    = '0;
            hdr_reg      = sre_pkg::HEADER_BYTES_RESET;
            frame_no     = sre_pkg::FRAME_SENTINEL;
            frame_len    = '0;
            frame_pixels = '0;
            slice_count  = '0;
            foreach (slice_got[i])
                slice_got[i] = 1'b0;
            got_count = '0;
            wr_addr   = 0;
            wr_left   = 0;
            wr_slice  = '0;
            wr_busy   = 1'b0;
            result_q.delete();
        end
        else
        begin
            // results first: an item accepted at this edge cannot be answered at it
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                    report_mismatch("unexpected item, status", 32'(m_tuser), '0);
                else
                begin
                    want = result_q.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tlast !== want.complete)
                        report_mismatch("frame_complete", 32'(m_tlast), 32'(want.complete));
                    if (m_tdata[31:0] !== want.frame_id)
                        report_mismatch("done_frame_id", m_tdata[31:0], want.frame_id);
                    if (m_tdata[63:32] !== want.pixels)
                        report_mismatch("done_pixel_count", m_tdata[63:32], want.pixels);
                    if (m_tdata[71:64] !== want.rdata)
                        report_mismatch("read_data", 32'(m_tdata[71:64]), 32'(want.rdata));
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    sre_pkg::REG_MAGIC_WORD:   magic_reg = cfg_wdata;
                    sre_pkg::REG_HEADER_BYTES: hdr_reg   = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                done       = 1'b0;
                want.rdata = '0;
                case (s_tuser)
                    sre_pkg::KIND_HEADER: want.status = take_header(s_tdata, done);
                    sre_pkg::KIND_BYTE:   want.status = take_byte(s_tdata[232:225], done);
                    sre_pkg::KIND_READ:
                    begin
                        want.rdata  = store_mem[s_tdata[248:233]];
                        want.status = sre_pkg::ST_READ_DONE;
                    end
                    default:              want.status = sre_pkg::ST_BYTE_IGNORE;
                endcase
                want.complete = done;
                want.frame_id = frame_no;
                want.pixels   = frame_pixels;
                result_q.insert(result_q.size(), want);
            end
        end
        outstanding = result_q.size();
    end

endmodule

>>> test/tb_top.sv
// Top of the slice reassembly engine testbench: clock, reset, config writes and
// stream stimulus; checking is done by slice_result_checker. Depends on sre_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] KIND_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         QUIET_LIMIT = 4000;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sre_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [31:0]                     cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [sre_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [sre_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [3:0]                      m_tuser;
    logic                            m_tlast;
    logic                            in_took;

    int fail_count;
    int outstanding;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_asked = 0;
    int hold_taken;
    int hold_left;
    int quiet      = 0;
    int items_done;

    logic [31:0] magic_cfg;
    logic [7:0]  hdr_cfg;
    logic [31:0] fid_next;
    logic [31:0] last_fid;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    slice_reassembly_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    slice_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    // note whether the input item was taken at the last rising edge
    always @(posedge clk)
        in_took <= s_tvalid && s_tready;

    // Receiver: random stalls, plus a long hold-off whenever one is asked for
    initial
    begin
        m_tready   = 1'b0;
        hold_taken = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_taken != hold_asked)
            begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= QUIET_LIMIT)
                begin
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    function automatic logic [sre_pkg::IN_TDATA_W-1:0] header_word(
        input logic [31:0] mg, input logic [31:0] fid, input logic [31:0] fsize,
        input logic [31:0] pix, input logic [15:0] snum, input logic [15:0] stot,
        input logic [31:0] off, input logic [15:0] plen, input logic [16:0] dlen);
        return {7'd0, 16'd0, 8'd0, dlen, plen, off, stot, snum, pix, fsize, fid, mg};
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic put_item(input logic [1:0] kind,
                            input logic [sre_pkg::IN_TDATA_W-1:0] word, input bit counted);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = word;
        @(negedge clk);
        while (!in_took)
            @(negedge clk);
        s_tvalid = 1'b0;
        if (counted)
            items_done++;
    endtask

    task automatic send_header(input logic [31:0] mg, input logic [31:0] fid,
                               input logic [31:0] fsize, input logic [31:0] pix,
                               input logic [15:0] snum, input logic [15:0] stot,
                               input logic [31:0] off, input logic [15:0] plen,
                               input logic [16:0] dlen);
        put_item(sre_pkg::KIND_HEADER,
                 header_word(mg, fid, fsize, pix, snum, stot, off, plen, dlen), 1'b1);
    endtask

    task automatic send_byte(input logic [7:0] b, input bit counted);
        logic [sre_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[232:225] = b;
        put_item(sre_pkg::KIND_BYTE, word, counted);
    endtask

    // Reads stay inside the two ranges written at the start of the run
    task automatic send_read();
        logic [sre_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[248:233] = $urandom_range(1) ? 16'($urandom_range(0, 7))
                                          : 16'($urandom_range(65528, 65535));
        put_item(sre_pkg::KIND_READ, word, 1'b1);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [sre_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_noise();
        logic [sre_pkg::IN_TDATA_W-1:0] word;
        logic [31:0] stale_fid;
        case ($urandom_range(7))
            0: send_byte(8'($urandom), 1'b0);
            1:
            begin
                word = {8{$urandom}};
                put_item(KIND_SPARE, word, 1'b0);
            end
            2, 3: send_read();
            4: send_header(~magic_cfg, $urandom, $urandom, $urandom, 16'($urandom),
                           16'($urandom), $urandom, 16'($urandom),
                           17'($urandom_range(0, 65536)));
            5: send_header(magic_cfg, fid_next, $urandom, $urandom, 16'($urandom),
                           16'($urandom), $urandom, 16'($urandom),
                           17'($urandom_range(0, hdr_cfg - 1)));
            6:
            begin
                // oversized frame: too big a store or too many slices
                if ($urandom_range(1))
                    send_header(magic_cfg, fid_next,
                                32'd65537 + $urandom_range(0, 32'h7fff_ffff), $urandom,
                                16'd0, 16'($urandom_range(1, 64)), 32'd0, 16'd0,
                                17'h1_0000);
                else
                    send_header(magic_cfg, fid_next, 32'($urandom_range(0, 65536)),
                                $urandom, 16'd0, 16'($urandom_range(65, 65535)), 32'd0,
                                16'd0, 17'h1_0000);
            end
            default:
            begin
                stale_fid = (last_fid == 0) ? last_fid : last_fid - 1;
                send_header(magic_cfg, ($urandom_range(1) ? stale_fid : last_fid), $urandom,
                            $urandom, 16'($urandom), 16'($urandom), $urandom,
                            16'($urandom), 17'($urandom_range(0, 65536)));
            end
        endcase
    endtask

    // One frame of well-formed slices in random order, with noise and the odd fault
    task automatic send_frame();
        int unsigned n;
        int unsigned base;
        int unsigned total;
        int unsigned fsize;
        int unsigned order [64];
        int unsigned lens [64];
        int unsigned offs [64];
        int unsigned i;
        int unsigned j;
        int unsigned tmp;
        int unsigned nb;
        logic [31:0] fid;
        logic [31:0] pix;
        logic [16:0] dlen;
        n = ($urandom_range(14) == 0) ? 64 : $urandom_range(1, 6);
        total = 0;
        for (int k = 0; k < n; k++)
        begin
            lens[k]  = (n == 64) ? $urandom_range(0, 1) : $urandom_range(0, 6);
            order[k] = k;
            total   += lens[k];
        end
        base  = ($urandom_range(9) == 0) ? 65536 - total : $urandom_range(0, 2000);
        fsize = base + total;
        if (fsize < 65536)
            fsize += $urandom_range(0, 2);
        for (int k = 0; k < n; k++)
            offs[k] = (k == 0) ? base : offs[k - 1] + lens[k - 1];
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        fid = ($urandom_range(29) == 0) ? 32'hFFFF_FFFF : fid_next;
        last_fid = fid;
        // after the sentinel any frame number restarts, so start low again
        fid_next = (fid == 32'hFFFF_FFFF) ? 32'($urandom_range(0, 2))
                                          : fid_next + $urandom_range(1, 3);
        pix = $urandom;
        for (int k = 0; k < n; k++)
        begin
            i = order[k];
            if ($urandom_range(9) == 0)
                send_noise();
            dlen = ($urandom_range(9) == 0) ? 17'h1_0000
                                            : 17'(hdr_cfg + lens[i] + $urandom_range(0, 3));
            send_header(magic_cfg, fid, fsize, pix, 16'(i), 16'(n), offs[i], 16'(lens[i]),
                        dlen);
            nb = lens[i];
            if (nb > 0 && $urandom_range(19) == 0)
                nb = $urandom_range(0, nb - 1);
            for (int b = 0; b < nb; b++)
                send_byte(8'($urandom), 1'b1);
            if ($urandom_range(24) == 0)
                send_header(magic_cfg, fid, fsize, pix, 16'(i), 16'(n), offs[i],
                            16'(lens[i]), dlen);
        end
    endtask

    task automatic run_directed();
        // fill two store ranges from the reset sentinel; the second slice completes
        send_header(magic_cfg, 32'd1, 32'd65536, 32'h0001_0203, 16'd0, 16'd2, 32'd0, 16'd8,
                    17'(hdr_cfg + 8));
        for (int b = 0; b < 8; b++)
            send_byte(8'(8'hA0 + b), 1'b1);
        send_header(magic_cfg, 32'd1, 32'd65536, 32'h0001_0203, 16'd1, 16'd2, 32'd65528,
                    16'd8, 17'(hdr_cfg + 8));
        send_byte(8'h00, 1'b1);
        for (int b = 1; b < 8; b++)
            send_byte(8'($urandom), 1'b1);
        send_read();
        send_byte(8'hFF, 1'b0);
        put_item(KIND_SPARE, '1, 1'b0);
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd0, 16'd1, 32'd0, 16'd0,
                    17'(hdr_cfg - 1));
        send_header(32'd0, 32'd2, 32'd100, 32'd0, 16'd0, 16'd1, 32'd0, 16'd0, 17'(hdr_cfg));
        send_header(magic_cfg, 32'd0, 32'd10, 32'd0, 16'd0, 16'd1, 32'd0, 16'd0, 17'(hdr_cfg));
        send_header(magic_cfg, 32'd2, 32'd65537, 32'd0, 16'd0, 16'd1, 32'd0, 16'd0,
                    17'(hdr_cfg));
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd0, 16'd65, 32'd0, 16'd0,
                    17'(hdr_cfg));
        // frame 2 opens with every slice index taken: index past the limit, then all ones
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd64, 16'd64, 32'd0, 16'd0,
                    17'(hdr_cfg));
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'hFFFF, 16'd64, 32'd0, 16'd0,
                    17'(hdr_cfg));
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd63, 16'd64, 32'd90, 16'd11,
                    17'(hdr_cfg + 11));
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd63, 16'd64, 32'd0, 16'd10,
                    17'(hdr_cfg + 9));
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd63, 16'd64, 32'd0, 16'd0,
                    17'(hdr_cfg));
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd63, 16'd64, 32'd0, 16'd0,
                    17'(hdr_cfg));
        // abandon a half-written slice with the next header
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd0, 16'd64, 32'd0, 16'd4,
                    17'(hdr_cfg + 4));
        send_byte(8'h5A, 1'b1);
        send_byte(8'hA5, 1'b1);
        send_header(magic_cfg, 32'd2, 32'd100, 32'd0, 16'd1, 16'd64, 32'd4, 16'd0,
                    17'(hdr_cfg));
        send_byte(8'h77, 1'b0);
        send_header(magic_cfg, 32'd3, 32'd10, 32'd7, 16'd0, 16'd0, 32'd0, 16'd0,
                    17'(hdr_cfg));
        // frame number equal to the sentinel, one empty slice
        send_header(magic_cfg, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'd0, 16'd1, 32'd0,
                    16'd0, 17'h1_0000);
        send_read();
        fid_next = '0;
        last_fid = 32'hFFFF_FFFF;
    endtask

    initial
    begin
        int target;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        items_done = 0;
        fid_next   = '0;
        last_fid   = '0;
        magic_cfg  = '0;
        hdr_cfg    = sre_pkg::HEADER_BYTES_RESET;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    magic_cfg = 32'hFFFF_FFFF;
                    hdr_cfg   = 8'd28;
                    send_idle = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    magic_cfg = 32'h0000_0000;
                    hdr_cfg   = 8'd255;
                    send_idle = 59;
                    recv_stall = 0;
                end
                2:
                begin
                    magic_cfg = $urandom;
                    hdr_cfg   = 8'd1;
                    send_idle = 0;
                    recv_stall = 59;
                end
                default:
                begin
                    magic_cfg = 32'h8000_0001;
                    hdr_cfg   = 8'd128;
                    send_idle = 7;
                    recv_stall = 7;
                end
            endcase
            write_reg(sre_pkg::REG_MAGIC_WORD, magic_cfg);
            write_reg(sre_pkg::REG_HEADER_BYTES, {24'd0, hdr_cfg});
            if (ph == 0)
            begin
                run_directed();
                // hold the receiver off while items keep coming, then let it all drain
                hold_asked++;
                target = items_done + 60;
                while (items_done < target)
                    send_frame();
                drain();
            end
            target = items_done + 100;
            while (items_done < target)
            begin
                send_frame();
                if ($urandom_range(7) == 0)
                    drain();
            end
        end
        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
